>>> hdl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, constants and codes for the spectrum peak-hold/decay core.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int BIN_W   = 6;    // bin number field
  localparam int MAG_W   = 16;   // Q0.16 magnitude / level
  localparam int COEF_W  = 17;   // Q1.16 coefficient, 65536 = 1.0
  localparam int CFG_A_W = 2;    // config register index
  localparam int SUM_W   = 32;   // frame level accumulator

  localparam logic [COEF_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [MAG_W-1:0]  FLOOR_Q16   = 16'd6554;   // 0.1
  localparam logic [COEF_W-1:0] DECAY_RESET = 17'd58982;  // 0.9
  localparam logic [COEF_W-1:0] GAIN_RESET  = 17'd65536;  // 1.0

  typedef enum logic [CFG_A_W-1:0] {
    CFG_DECAY = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_RUN   = 2'd2
  } cfg_idx_t;

  typedef logic [BIN_W-1:0]  bin_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [COEF_W-1:0] coef_t;

endpackage

>>> hdl/spd_in_if.sv
// ----------------------------------------------------------------------------
// spd_in_if
// Input beat channel: one spectrum bin magnitude per beat.
// ----------------------------------------------------------------------------
interface spd_in_if;
  import spd_pkg::*;

  logic valid;
  logic ready;
  bin_t bin_index;
  mag_t magnitude;
  logic frame_last;

  modport source (output valid, output bin_index, output magnitude, output frame_last,
                  input ready);
  modport sink   (input valid, input bin_index, input magnitude, input frame_last,
                  output ready);
endinterface

>>> hdl/spd_out_if.sv
// ----------------------------------------------------------------------------
// spd_out_if
// Result beat channel: one smoothed bin level per beat, frame stats on last.
// ----------------------------------------------------------------------------
interface spd_out_if;
  import spd_pkg::*;

  logic valid;
  logic ready;
  bin_t out_bin;
  mag_t level;
  mag_t frame_average;
  mag_t frame_peak;
  logic frame_done;

  modport source (output valid, output out_bin, output level, output frame_average,
                  output frame_peak, output frame_done, input ready);
  modport sink   (input valid, input out_bin, input level, input frame_average,
                  input frame_peak, input frame_done, output ready);
endinterface

>>> hdl/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module spd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/spectrum_peak_hold_decay_core.sv
// ----------------------------------------------------------------------------
// spectrum_peak_hold_decay_core
// Per-bin peak hold with multiplicative decay over a streamed spectrum.
// ----------------------------------------------------------------------------
// Takes one bin magnitude per beat and returns one smoothed level per beat, in
// order. Throughput is one beat per clock unless out_ch.ready holds the stages
// or the clearing pass runs. The result passes three register stages (scale
// multiply, level read/decay/write-back, frame accumulate). Levels live in a
// BINS-deep RAM with one write and one registered read port; an item that
// reads a bin written by the item just ahead of it takes the fresh value from
// a bypass register. After reset a clearing pass writes zero to every bin, one
// per clock, and in.ready stays low until it is done (config writes are taken
// throughout). Config writes are only legal while no beat is in flight.
// frame_average and frame_peak are nonzero only on the beat with frame_done
// set.
// ----------------------------------------------------------------------------
module spectrum_peak_hold_decay_core #(
  parameter int BINS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spd_in_if.sink                        in_ch,
  spd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [spd_pkg::COEF_W-1:0]    cfg_wdata
);
  import spd_pkg::*;

  localparam int AW     = $clog2(BINS);
  localparam int CW     = (AW > BIN_W ? AW : BIN_W) + 1;
  localparam int AVG_SH = $clog2(BINS + 1) - 1;   // floor(log2 BINS)

  // ---------------- config registers ----------------
  coef_t decay_r, gain_r;
  logic  run_r;
  coef_t decay_lim, gain_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
      gain_r  <= GAIN_RESET;
      run_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DECAY: decay_r <= cfg_wdata;
        CFG_GAIN:  gain_r  <= cfg_wdata;
        CFG_RUN:   run_r   <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // anything above 1.0 acts as 1.0
  assign decay_lim = (decay_r > ONE_Q16) ? ONE_Q16 : decay_r;
  assign gain_lim  = (gain_r  > ONE_Q16) ? ONE_Q16 : gain_r;

  // ---------------- clearing pass ----------------
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(BINS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------- stage handshake ----------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic en_out, en2, en1, in_fire;

  assign en_out  = !out_valid_r || out_ch.ready;
  assign en2     = !s2_valid_r || en_out;
  assign en1     = !s1_valid_r || en2;
  assign in_ch.ready = en1 && !clr_active_r;
  assign in_fire = in_ch.valid && in_ch.ready;

  // ---------------- stage 1: input scale, RAM read issued ----------------
  logic [2*MAG_W:0] scale_prod;
  bin_t             s1_bin_r;
  logic             s1_last_r, s1_inr_r;
  mag_t             s1_scaled_r;
  logic             in_range;

  assign scale_prod = in_ch.magnitude * gain_lim;
  assign in_range   = CW'(in_ch.bin_index) < CW'(BINS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_bin_r    <= in_ch.bin_index;
      s1_last_r   <= in_ch.frame_last;
      s1_inr_r    <= in_range;
      s1_scaled_r <= scale_prod[2*MAG_W-1:MAG_W];   // gain <= 1.0 keeps it in 16 bits
    end
  end

  // ---------------- level RAM ----------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr, s1_addr;
  mag_t          ram_wdata, ram_rdata;
  logic          item_we;

  assign s1_addr   = AW'(s1_bin_r);
  assign item_we   = en2 && s1_valid_r && s1_inr_r && run_r;
  assign ram_we    = clr_active_r || item_we;
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr;

  spd_ram #(
    .WIDTH (MAG_W),
    .DEPTH (BINS)
  ) u_levels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en1),
    .raddr (AW'(in_ch.bin_index)),
    .rdata (ram_rdata)
  );

  // bypass: last write made at the same edge the current stage-1 read was taken
  logic          byp_valid_r;
  logic [AW-1:0] byp_addr_r;
  mag_t          byp_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (en1) begin
      byp_valid_r <= item_we;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      byp_addr_r <= s1_addr;
      byp_data_r <= ram_wdata;
    end
  end

  // ---------------- stage 1 compute: decay, peak compare ----------------
  mag_t             lev_old, lev_sel, lev_new;
  logic [2*MAG_W:0] decay_prod;
  mag_t             decayed;

  assign lev_old    = (byp_valid_r && byp_addr_r == s1_addr) ? byp_data_r : ram_rdata;
  assign decay_prod = lev_old * decay_lim;
  assign decayed    = decay_prod[2*MAG_W-1:MAG_W];

  always_comb begin
    lev_sel = decayed;
    if (decayed < s1_scaled_r) begin
      // small nonzero input is lifted to the 0.1 floor
      lev_sel = (s1_scaled_r < FLOOR_Q16) ? FLOOR_Q16 : s1_scaled_r;
    end
    if (!s1_inr_r) begin
      lev_new = '0;
    end else if (run_r) begin
      lev_new = lev_sel;
    end else begin
      lev_new = lev_old;
    end
  end

  assign ram_wdata = clr_active_r ? '0 : lev_new;

  // ---------------- stage 2: level out of the RMW loop ----------------
  bin_t s2_bin_r;
  mag_t s2_lev_r;
  logic s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_bin_r  <= s1_bin_r;
      s2_lev_r  <= lev_new;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------- frame accumulate ----------------
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_upd;
  mag_t             max_r, max_nxt, max_upd;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] avg_wide;
  mag_t             avg_val;
  logic             s2_fire;

  assign s2_fire  = s2_valid_r && en_out;
  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(s2_lev_r);
  assign sum_upd  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign max_upd  = (s2_lev_r > max_r) ? s2_lev_r : max_r;
  assign avg_wide = sum_upd >> AVG_SH;
  assign avg_val  = (avg_wide > SUM_W'(16'hFFFF)) ? 16'hFFFF : avg_wide[MAG_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    max_nxt = max_r;
    if (s2_fire) begin
      sum_nxt = s2_last_r ? '0 : sum_upd;
      max_nxt = s2_last_r ? '0 : max_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      max_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      max_r <= max_nxt;
    end
  end

  // ---------------- output register ----------------
  bin_t out_bin_r;
  mag_t out_lev_r, out_avg_r, out_peak_r;
  logic out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_bin_r  <= s2_bin_r;
      out_lev_r  <= s2_lev_r;
      out_avg_r  <= s2_last_r ? avg_val : '0;
      out_peak_r <= s2_last_r ? max_upd : '0;
      out_done_r <= s2_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_bin       = out_bin_r;
  assign out_ch.level         = out_lev_r;
  assign out_ch.frame_average = out_avg_r;
  assign out_ch.frame_peak    = out_peak_r;
  assign out_ch.frame_done    = out_done_r;

  // ---------------- assertions ----------------
  // clearing pass owns the RAM write port
  a_clr_no_item_write: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !item_we)
    else $error("item write during clearing pass");

  // no beat taken before the store is cleared
  a_clr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

  // frame stats only travel on the closing beat
  a_stats_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> (out_avg_r == '0 && out_peak_r == '0))
    else $error("frame stats on a non-final beat");

  // a stalled stage-1 item keeps its RAM word: nothing else may write meanwhile
  a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !en2) |-> !ram_we)
    else $error("RAM written while stage 1 stalled");

endmodule

>>> tb/sv/tb_spectrum_peak_hold_decay_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spectrum_peak_hold_decay_core
// Self-checking bench for the per-bin peak-hold/decay core.
// ----------------------------------------------------------------------------
// Bin magnitudes go in on the input channel. An in-bench model of the level
// store and the frame accumulators predicts one result per accepted beat.
// Results are checked in order, field by field. A short directed table covers
// the hold mode, the 0.1 floor, tiny inputs, clamped coefficients and the
// frame statistics. Random phases with fresh register settings follow: mostly
// whole 64-bin frames, plus frames of odd length with scattered bins. Both
// sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_spectrum_peak_hold_decay_core;
  import spd_pkg::*;

  localparam int BINS      = 64;
  localparam int AVG_SHIFT = $clog2(BINS);   // BINS is a power of two
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 300;           // beats per random phase, at least

  // index 3 has no register behind it; writes to it must be ignored
  localparam logic [CFG_A_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // one line of the directed table: a beat or a register write
  typedef struct {
    row_kind_t           kind;
    logic [CFG_A_W-1:0]  reg_idx;
    bin_t                bin;
    coef_t               value;     // magnitude for a beat, data for a write
    logic                last;
    bit                  fixed;     // expected result typed in below
    mag_t                lv;
    mag_t                avg;
    mag_t                pk;
  } dir_row_t;

  typedef struct {
    bin_t  bin;
    mag_t  level;
    mag_t  avg;
    mag_t  peak;
    logic  done;
  } level_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_A_W-1:0] cfg_index;
  coef_t cfg_wdata;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  // sideband that travels with each input beat: typed-in expectation
  bit   tag_fixed;
  mag_t tag_level;
  mag_t tag_avg;
  mag_t tag_peak;

  bit burst;                 // both sides run without gaps while set
  int unsigned err_count;

  // predictor state
  mag_t        lvl_store [BINS];
  logic [31:0] sum_acc;
  mag_t        max_acc;
  coef_t       decay_reg;
  coef_t       gain_reg;
  logic        run_reg;

  level_beat_t level_q [$];
  dir_row_t    dir_tab [$];

  spectrum_peak_hold_decay_core #(
    .BINS (BINS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Level predictor
  // --------------------------------------------------------------------------
  function automatic coef_t clamp_one(coef_t v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic level_beat_t predict_level(bin_t b, mag_t m, logic last);
    level_beat_t r;
    logic [32:0] prod;
    mag_t        scaled;
    mag_t        decayed;
    mag_t        lv;
    logic [32:0] sum_next;
    lv = '0;
    if (int'(b) < BINS) begin
      lv = lvl_store[b];
      if (run_reg) begin
        prod    = {17'd0, m} * {16'd0, clamp_one(gain_reg)};
        scaled  = prod[31:16];
        prod    = {17'd0, lv} * {16'd0, clamp_one(decay_reg)};
        decayed = prod[31:16];
        if (decayed < scaled) begin
          // nonzero but quiet inputs are lifted to the 0.1 floor
          lv = (scaled != '0 && scaled < FLOOR_Q16) ? FLOOR_Q16 : scaled;
        end else begin
          lv = decayed;
        end
        lvl_store[b] = lv;
      end
    end
    sum_next = {1'b0, sum_acc} + {17'd0, lv};
    sum_acc  = sum_next[32] ? 32'hFFFF_FFFF : sum_next[31:0];
    if (lv > max_acc) max_acc = lv;
    r.bin   = b;
    r.level = lv;
    r.avg   = '0;
    r.peak  = '0;
    r.done  = last;
    if (last) begin
      r.avg   = ((sum_acc >> AVG_SHIFT) > 32'hFFFF) ? 16'hFFFF : sum_acc[AVG_SHIFT +: MAG_W];
      r.peak  = max_acc;
      sum_acc = '0;
      max_acc = '0;
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: register writes and input beats feed the predictor, result beats
  // are checked against the oldest expectation. All sampling at the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    level_beat_t e;
    if (!rst_n) begin
      foreach (lvl_store[i]) lvl_store[i] = '0;
      sum_acc   = '0;
      max_acc   = '0;
      decay_reg = DECAY_RESET;
      gain_reg  = GAIN_RESET;
      run_reg   = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECAY: decay_reg = cfg_wdata;
          CFG_GAIN:  gain_reg  = cfg_wdata;
          CFG_RUN:   run_reg   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (level_q.size() == 0) begin
          $error("result beat with nothing expected: bin %0d level %0d",
                 out_ch.out_bin, out_ch.level);
          err_count++;
        end else begin
          e = level_q.pop_front();
          check_field("out_bin",       32'(e.bin),   32'(out_ch.out_bin));
          check_field("level",         32'(e.level), 32'(out_ch.level));
          check_field("frame_average", 32'(e.avg),   32'(out_ch.frame_average));
          check_field("frame_peak",    32'(e.peak),  32'(out_ch.frame_peak));
          check_field("frame_done",    32'(e.done),  32'(out_ch.frame_done));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        e = predict_level(in_ch.bin_index, in_ch.magnitude, in_ch.frame_last);
        if (tag_fixed) begin
          e.level = tag_level;
          e.avg   = tag_avg;
          e.peak  = tag_peak;
        end
        level_q.push_back(e);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // magnitudes weighted toward the edges of the floor and the range
  function automatic mag_t pick_mag();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return mag_t'($urandom_range(1, FLOOR_Q16 - 1));
      3:       return mag_t'($urandom_range(FLOOR_Q16 - 4, FLOOR_Q16 + 4));
      default: return mag_t'($urandom);
    endcase
  endfunction

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ONE_Q16;
      2:       return 17'h1FFFF;
      3:       return coef_t'($urandom_range(58000, 65536));
      4:       return coef_t'($urandom_range(0, 65536));
      default: return coef_t'($urandom);
    endcase
  endfunction

  // returns once the core has taken the beat
  task automatic send_beat(bin_t b, mag_t m, logic last, bit fixed,
                           mag_t lv, mag_t avg, mag_t pk);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.bin_index  <= b;
    in_ch.magnitude  <= m;
    in_ch.frame_last <= last;
    tag_fixed        <= fixed;
    tag_level        <= lv;
    tag_avg          <= avg;
    tag_peak         <= pk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop sending and let every expected beat come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
  endtask

  // one write per call; the enable is dropped again before returning
  task automatic write_reg(logic [CFG_A_W-1:0] idx, coef_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic dir_row_t beat_row(bin_t b, mag_t m, logic last, bit fixed,
                                        mag_t lv, mag_t avg, mag_t pk);
    dir_row_t r;
    r.kind = ROW_BEAT; r.reg_idx = '0; r.bin = b; r.value = {1'b0, m};
    r.last = last; r.fixed = fixed; r.lv = lv; r.avg = avg; r.pk = pk;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_A_W-1:0] idx, coef_t data);
    dir_row_t r;
    r = beat_row('0, '0, 1'b0, 1'b0, '0, '0, '0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = data;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side backpressure
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall != 0 && !burst) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned len;
    logic        last;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.bin_index  = '0;
    in_ch.magnitude  = '0;
    in_ch.frame_last = 1'b0;
    tag_fixed        = 1'b0;
    tag_level        = '0;
    tag_avg          = '0;
    tag_peak         = '0;
    burst            = 1'b0;
    err_count        = 0;

    // hold mode straight out of reset: store reads back cleared
    dir_tab.push_back(beat_row(0,  16'hFFFF, 1'b0, 1, 0, 0, 0));
    dir_tab.push_back(beat_row(63, 16'h0000, 1'b1, 1, 0, 0, 0));
    // running with reset coefficients (decay 0.9, gain 1.0)
    dir_tab.push_back(cfg_row(CFG_RUN, 17'd1));
    dir_tab.push_back(beat_row(0,  16'hFFFF, 1'b0, 1, 16'hFFFF, 0, 0));
    dir_tab.push_back(beat_row(1,  16'd100,  1'b0, 1, FLOOR_Q16, 0, 0));  // lifted to 0.1
    dir_tab.push_back(beat_row(2,  FLOOR_Q16, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(beat_row(3,  mag_t'(FLOOR_Q16 - 16'd1), 1'b0, 1, FLOOR_Q16, 0, 0));
    dir_tab.push_back(beat_row(0,  16'h0000, 1'b1, 0, 0, 0, 0));         // decay + stats
    // gain of one LSB: input truncates to zero and gets no floor
    dir_tab.push_back(cfg_row(CFG_GAIN, 17'd1));
    dir_tab.push_back(beat_row(4,  16'hFFFF, 1'b0, 1, 0, 0, 0));
    // coefficients above 1.0 act as 1.0
    dir_tab.push_back(cfg_row(CFG_GAIN, 17'h1FFFF));
    dir_tab.push_back(cfg_row(CFG_DECAY, 17'h1FFFF));
    dir_tab.push_back(beat_row(1,  16'h0000, 1'b0, 1, FLOOR_Q16, 0, 0));
    dir_tab.push_back(beat_row(5,  16'hFFFF, 1'b0, 1, 16'hFFFF, 0, 0));
    // zero decay wipes a level in one step
    dir_tab.push_back(cfg_row(CFG_DECAY, 17'd0));
    dir_tab.push_back(beat_row(0,  16'h0000, 1'b0, 1, 0, 0, 0));
    dir_tab.push_back(beat_row(5,  16'd30000, 1'b0, 1, 16'd30000, 0, 0));
    dir_tab.push_back(beat_row(63, 16'hFFFF, 1'b1, 0, 0, 0, 0));
    // hold again: levels come back untouched but still feed the stats
    dir_tab.push_back(cfg_row(CFG_RUN, 17'd0));
    dir_tab.push_back(beat_row(5,  16'h0000, 1'b0, 1, 16'd30000, 0, 0));
    dir_tab.push_back(beat_row(63, 16'h0000, 1'b1, 0, 0, 0, 0));
    // write to the unmapped index changes nothing
    dir_tab.push_back(cfg_row(CFG_SPARE, 17'h1FFFF));
    dir_tab.push_back(beat_row(5,  16'hFFFF, 1'b1, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        send_beat(dir_tab[i].bin, dir_tab[i].value[MAG_W-1:0], dir_tab[i].last,
                  dir_tab[i].fixed, dir_tab[i].lv, dir_tab[i].avg, dir_tab[i].pk);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == 0) begin
        // full hold, full gain: long frames push the average into saturation
        write_reg(CFG_DECAY, ONE_Q16);
        write_reg(CFG_GAIN,  ONE_Q16);
        write_reg(CFG_RUN,   17'd1);
      end else if (p == 1) begin
        write_reg(CFG_DECAY, 17'd0);
        write_reg(CFG_GAIN,  17'h1FFFF);
      end else begin
        write_reg(CFG_DECAY, pick_coef());
        write_reg(CFG_GAIN,  pick_coef());
        write_reg(CFG_RUN,   coef_t'($urandom_range(0, 99) < 80));
      end
      sent = 0;
      while (sent < PHASE_LEN) begin
        burst = ($urandom_range(0, 99) < 20);
        if ($urandom_range(0, 99) < 85) begin
          // well-formed frame, bins in order
          for (int b = 0; b < BINS; b++) begin
            send_beat(bin_t'(b), pick_mag(), b == BINS - 1, 0, 0, 0, 0);
          end
          sent += BINS;
        end else begin
          // odd length, scattered bins, occasional early frame ends
          len = $urandom_range(1, 130);
          for (int k = 0; k < len; k++) begin
            last = (k == len - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
            send_beat(bin_t'($urandom_range(0, BINS - 1)), pick_mag(), last, 0, 0, 0, 0);
          end
          sent += len;
        end
      end
      burst = 1'b0;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> spectrum_peak_hold_decay_core.f
hdl/spd_pkg.sv
hdl/spd_in_if.sv
hdl/spd_out_if.sv
hdl/spd_ram.sv
hdl/spectrum_peak_hold_decay_core.sv
tb/sv/tb_spectrum_peak_hold_decay_core.sv
